/* src/dhsr_pkg.sv */
// shared types, constants and command codes for the dual h-bridge slew ramp
// no dependencies
package dhsr_pkg;

    localparam int DUTY_BITS_DEF = 16;
    localparam int FIELD_W       = 16;
    localparam int LIMIT_W       = 10;
    localparam int STALL_W       = 11;
    localparam int PCT_W         = 8;
    localparam int OP_W          = 2;
    localparam int CFG_IDX_W     = 2;

    localparam int PROD_W        = 24;
    localparam int RECIP_W       = 25;
    localparam int RECIP_SHIFT   = 31;
    localparam int QUOT_W        = 18;
    localparam int MUL_W         = PROD_W + RECIP_W;

    localparam int S_TDATA_W     = 24;
    localparam int S_TUSER_W     = 3;
    localparam int M_TDATA_W     = 72;

    // ceil(2^31 / 100), exact floor division for any 24-bit dividend
    localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;

    localparam logic [FIELD_W-1:0] PERIOD_RST      = 16'd1000;
    localparam logic [FIELD_W-1:0] RAMP_STEP_RST   = 16'd10;
    localparam logic [LIMIT_W-1:0] STALL_LIMIT_RST = 10'd100;
    localparam logic [STALL_W-1:0] STALL_SAT       = 11'd2047;
    localparam logic [PCT_W-1:0]   PCT_SPLIT       = 8'd50;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_SPOOL = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd3;

    localparam logic MOTOR_A = 1'b0;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               sel;
        logic [FIELD_W-1:0] duty;
        logic               spool_b;
        logic [PROD_W-1:0]  prod;
    } prod_item_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               sel;
        logic [FIELD_W-1:0] duty;
        logic               spool_b;
        logic [QUOT_W-1:0]  quot;
    } cmd_item_t;

    typedef struct packed {
        logic moving;
        logic stall_hit;
    } ramp_flags_t;

    typedef struct packed {
        logic               stall_trip;
        logic [FIELD_W-1:0] duty_motor_b;
        logic [FIELD_W-1:0] duty_motor_a;
        logic               bridge_enable;
        logic [FIELD_W-1:0] channel_two_compare;
        logic [FIELD_W-1:0] channel_one_compare;
    } result_t;

endpackage

/* src/dual_hbridge_slew_ramp.sv */
// dual h-bridge slew ramp: an s_ word reaches its m_ word through three registers (input/product,
// divide-by-100 quotient, motor state and result), one word per cycle unless m_tready stalls.
// throughput is set by the per-motor ramp logic closing combinationally on the state registers.
// aresetn (synchronous, active low) clears duties, targets, stall counts, compares and the bridge
// enable, empties the pipe and loads period 1000, ramp step 10, stall limit 100.
module dual_hbridge_slew_ramp import dhsr_pkg::*; #(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [FIELD_W-1:0]     cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // duty_value, spool_percent
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // operation, motor_select
    input  logic [S_TUSER_W-1:0]   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // channel_one_compare, channel_two_compare, bridge_enable, duty_motor_a, duty_motor_b,
    // stall_trip, zero pad
    output logic [M_TDATA_W-1:0]   m_tdata
);

    localparam logic [FIELD_W-1:0] DUTY_MAX_F = FIELD_W'((32'd1 << DUTY_BITS) - 32'd1);

    logic [FIELD_W-1:0]   period_reg;
    logic [FIELD_W-1:0]   ramp_step_reg;
    logic [LIMIT_W-1:0]   stall_limit_reg;
    logic [DUTY_BITS-1:0] clamp_period;
    logic                 cmd_valid, cmd_ready;
    cmd_item_t            cmd;
    result_t              res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg      <= PERIOD_RST;
            ramp_step_reg   <= RAMP_STEP_RST;
            stall_limit_reg <= STALL_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_PERIOD:      period_reg      <= cfg_wr_data;
                REG_RAMP_STEP:   ramp_step_reg   <= cfg_wr_data;
                REG_STALL_LIMIT: stall_limit_reg <= cfg_wr_data[LIMIT_W-1:0];
                default: begin
                    period_reg <= period_reg;
                end
            endcase
        end
    end

    assign clamp_period = (period_reg > DUTY_MAX_F) ? DUTY_BITS'(DUTY_MAX_F)
                                                    : DUTY_BITS'(period_reg);

    dhsr_scale #(.DUTY_BITS(DUTY_BITS)) u_scale (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (s_tuser[OP_W-1:0]),
        .in_sel       (s_tuser[OP_W]),
        .in_duty      (s_tdata[FIELD_W-1:0]),
        .in_pct       (s_tdata[FIELD_W +: PCT_W]),
        .clamp_period (clamp_period),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    dhsr_core #(.DUTY_BITS(DUTY_BITS)) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .clamp_period (clamp_period),
        .ramp_step    (ramp_step_reg),
        .stall_limit  (stall_limit_reg),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res          (res)
    );

    assign m_tdata = M_TDATA_W'(res);

endmodule

/* src/dhsr_scale.sv */
// input register and spool scaling: pct * period, then divide by 100
// depends on dhsr_pkg
module dhsr_scale import dhsr_pkg::*; #(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       in_op,
    input  logic                  in_sel,
    input  logic [FIELD_W-1:0]    in_duty,
    input  logic [PCT_W-1:0]      in_pct,
    input  logic [DUTY_BITS-1:0]  clamp_period,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output cmd_item_t             cmd
);

    logic       s1_valid_reg, s1_valid_next;
    prod_item_t s1_item_reg;
    logic       s2_valid_reg, s2_valid_next;
    cmd_item_t  s2_item_reg;
    logic       s2_ready;
    logic       load1;
    logic [MUL_W-1:0] recip_mul;

    assign s2_ready = !s2_valid_reg || cmd_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign load1    = in_valid && in_ready;

    always_comb begin
        if (load1) begin
            s1_valid_next = 1'b1;
        end else if (s2_ready) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    assign recip_mul = MUL_W'(s1_item_reg.prod) * MUL_W'(RECIP_100);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            s1_item_reg.op      <= in_op;
            s1_item_reg.sel     <= in_sel;
            s1_item_reg.duty    <= in_duty;
            s1_item_reg.spool_b <= (in_pct <= PCT_SPLIT);
            s1_item_reg.prod    <= PROD_W'(in_pct) * PROD_W'(clamp_period);
        end
        if (s2_ready && s1_valid_reg) begin
            s2_item_reg.op      <= s1_item_reg.op;
            s2_item_reg.sel     <= s1_item_reg.sel;
            s2_item_reg.duty    <= s1_item_reg.duty;
            s2_item_reg.spool_b <= s1_item_reg.spool_b;
            s2_item_reg.quot    <= recip_mul[RECIP_SHIFT +: QUOT_W];
        end
    end

    assign cmd_valid = s2_valid_reg;
    assign cmd       = s2_item_reg;

endmodule

/* src/dhsr_ramp.sv */
// one motor's slew step toward its target with stall counting
// depends on dhsr_pkg
module dhsr_ramp import dhsr_pkg::*; #(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic [DUTY_BITS-1:0] tgt,
    input  logic [DUTY_BITS-1:0] cur,
    input  logic [STALL_W-1:0]   cnt,
    input  logic [FIELD_W-1:0]   ramp_step,
    input  logic [LIMIT_W-1:0]   stall_limit,
    output logic [DUTY_BITS-1:0] nxt,
    output logic [STALL_W-1:0]   cnt_next,
    output ramp_flags_t          flags
);

    logic [FIELD_W:0]      up_sum;
    logic [DUTY_BITS-1:0]  up_nxt;
    logic [FIELD_W-1:0]    dn_base;
    logic [DUTY_BITS-1:0]  dn_nxt;
    logic [STALL_W-1:0]    cnt_inc;
    logic                  moving;
    logic                  no_progress;

    assign moving  = (cur != tgt);
    assign up_sum  = (FIELD_W+1)'(cur) + (FIELD_W+1)'(ramp_step);
    assign up_nxt  = (up_sum > (FIELD_W+1)'(tgt)) ? tgt : DUTY_BITS'(up_sum);
    assign dn_base = (FIELD_W'(cur) > ramp_step) ? FIELD_W'(cur) - ramp_step : '0;
    assign dn_nxt  = (dn_base < FIELD_W'(tgt)) ? tgt : DUTY_BITS'(dn_base);
    assign cnt_inc = (cnt == STALL_SAT) ? cnt : cnt + STALL_W'(1);

    always_comb begin
        if (!moving) begin
            nxt = cur;
        end else if (cur < tgt) begin
            nxt = up_nxt;
        end else begin
            nxt = dn_nxt;
        end
    end

    assign no_progress = moving && (nxt == cur);
    assign cnt_next    = no_progress ? cnt_inc : '0;

    assign flags.moving    = moving;
    assign flags.stall_hit = no_progress && (cnt_inc > STALL_W'(stall_limit));

endmodule

/* src/dhsr_core.sv */
// motor state, command decode, interlock and result register
// depends on dhsr_pkg and dhsr_ramp
module dhsr_core import dhsr_pkg::*; #(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_item_t             cmd,
    input  logic [DUTY_BITS-1:0]  clamp_period,
    input  logic [FIELD_W-1:0]    ramp_step,
    input  logic [LIMIT_W-1:0]    stall_limit,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res
);

    logic [DUTY_BITS-1:0] tgt_a_reg, tgt_a_next, tgt_b_reg, tgt_b_next;
    logic [DUTY_BITS-1:0] cur_a_reg, cur_a_next, cur_b_reg, cur_b_next;
    logic [STALL_W-1:0]   cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [DUTY_BITS-1:0] cmp1_reg, cmp1_next, cmp2_reg, cmp2_next;
    logic                 en_reg, en_next;
    logic                 trip_reg, trip_next;
    logic                 valid_reg, valid_next;
    logic                 adv;

    logic [DUTY_BITS-1:0] il_a, il_b;
    logic [DUTY_BITS-1:0] nxt_a, nxt_b;
    logic [STALL_W-1:0]   rcnt_a, rcnt_b;
    ramp_flags_t          flags_a, flags_b;
    logic [DUTY_BITS-1:0] set_duty, spool_duty;

    assign cmd_ready = !valid_reg || res_ready;
    assign adv       = cmd_valid && cmd_ready;

    // interlock: keep only the larger target, b loses a tie
    always_comb begin
        il_a = tgt_a_reg;
        il_b = tgt_b_reg;
        if ((tgt_a_reg != '0) && (tgt_b_reg != '0)) begin
            if (tgt_a_reg < tgt_b_reg) begin
                il_a = '0;
            end else begin
                il_b = '0;
            end
        end
    end

    dhsr_ramp #(.DUTY_BITS(DUTY_BITS)) u_ramp_a (
        .tgt         (il_a),
        .cur         (cur_a_reg),
        .cnt         (cnt_a_reg),
        .ramp_step   (ramp_step),
        .stall_limit (stall_limit),
        .nxt         (nxt_a),
        .cnt_next    (rcnt_a),
        .flags       (flags_a)
    );

    dhsr_ramp #(.DUTY_BITS(DUTY_BITS)) u_ramp_b (
        .tgt         (il_b),
        .cur         (cur_b_reg),
        .cnt         (cnt_b_reg),
        .ramp_step   (ramp_step),
        .stall_limit (stall_limit),
        .nxt         (nxt_b),
        .cnt_next    (rcnt_b),
        .flags       (flags_b)
    );

    assign set_duty   = (cmd.duty > FIELD_W'(clamp_period)) ? clamp_period
                                                            : DUTY_BITS'(cmd.duty);
    assign spool_duty = (cmd.quot > QUOT_W'(clamp_period)) ? clamp_period
                                                           : DUTY_BITS'(cmd.quot);

    always_comb begin
        tgt_a_next = tgt_a_reg;
        tgt_b_next = tgt_b_reg;
        cur_a_next = cur_a_reg;
        cur_b_next = cur_b_reg;
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        cmp1_next  = cmp1_reg;
        cmp2_next  = cmp2_reg;
        en_next    = en_reg;
        trip_next  = 1'b0;
        unique case (cmd.op)
            OP_TICK: begin
                if (!en_reg) begin
                    cmp1_next = '0;
                    cmp2_next = '0;
                end else begin
                    tgt_a_next = il_a;
                    tgt_b_next = il_b;
                    cur_a_next = nxt_a;
                    cur_b_next = nxt_b;
                    cnt_a_next = rcnt_a;
                    cnt_b_next = rcnt_b;
                    if (flags_a.moving) begin
                        cmp1_next = nxt_a;
                        cmp2_next = '0;
                    end
                    if (flags_b.moving) begin
                        cmp1_next = '0;
                        cmp2_next = nxt_b;
                    end
                    if (flags_a.stall_hit || flags_b.stall_hit) begin
                        tgt_a_next = '0;
                        tgt_b_next = '0;
                        en_next    = 1'b0;
                        cmp1_next  = '0;
                        cmp2_next  = '0;
                        trip_next  = 1'b1;
                    end
                end
            end
            OP_SET: begin
                if (cmd.sel == MOTOR_A) begin
                    tgt_a_next = set_duty;
                end else begin
                    tgt_b_next = set_duty;
                end
            end
            OP_SPOOL: begin
                if (cmd.spool_b) begin
                    tgt_a_next = '0;
                    tgt_b_next = spool_duty;
                end else begin
                    tgt_a_next = spool_duty;
                    tgt_b_next = '0;
                end
                en_next = 1'b1;
            end
            OP_STOP: begin
                tgt_a_next = '0;
                tgt_b_next = '0;
                en_next    = 1'b0;
                cmp1_next  = '0;
                cmp2_next  = '0;
            end
            default: begin
                en_next = en_reg;
            end
        endcase
    end

    always_comb begin
        if (adv) begin
            valid_next = 1'b1;
        end else if (res_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_a_reg <= '0;
            tgt_b_reg <= '0;
            cur_a_reg <= '0;
            cur_b_reg <= '0;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            cmp1_reg  <= '0;
            cmp2_reg  <= '0;
            en_reg    <= 1'b0;
            trip_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (adv) begin
                tgt_a_reg <= tgt_a_next;
                tgt_b_reg <= tgt_b_next;
                cur_a_reg <= cur_a_next;
                cur_b_reg <= cur_b_next;
                cnt_a_reg <= cnt_a_next;
                cnt_b_reg <= cnt_b_next;
                cmp1_reg  <= cmp1_next;
                cmp2_reg  <= cmp2_next;
                en_reg    <= en_next;
                trip_reg  <= trip_next;
            end
        end
    end

    // the state registers double as the result word: they only move when a word is loaded
    assign res_valid                = valid_reg;
    assign res.channel_one_compare  = FIELD_W'(cmp1_reg);
    assign res.channel_two_compare  = FIELD_W'(cmp2_reg);
    assign res.bridge_enable        = en_reg;
    assign res.duty_motor_a         = FIELD_W'(cur_a_reg);
    assign res.duty_motor_b         = FIELD_W'(cur_b_reg);
    assign res.stall_trip           = trip_reg;

`ifndef ASSERT_OFF
    a_trip_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        trip_reg |-> (!en_reg && cmp1_reg == '0 && cmp2_reg == '0
                      && tgt_a_reg == '0 && tgt_b_reg == '0))
        else $error("stall trip without full stop");

    a_trip_only_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && cmd.op != OP_TICK) |=> !trip_reg)
        else $error("stall trip on a non-tick command");

    a_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && cmd.op == OP_TICK && en_reg) |=> (tgt_a_reg == '0 || tgt_b_reg == '0))
        else $error("both targets nonzero after an enabled tick");

    a_duty_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && cmd.op != OP_TICK) |=> ($stable(cur_a_reg) && $stable(cur_b_reg)))
        else $error("duty moved outside a tick");

    a_spool_enables: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && cmd.op == OP_SPOOL) |=> en_reg)
        else $error("spool command left bridge disabled");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !res_ready) |=> (valid_reg && $stable(cur_a_reg) && $stable(cmp1_reg)))
        else $error("result word changed while stalled");
`endif

endmodule
